@@ rtl/dra_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the request admission and dispatch block.
// No dependencies; used by dra_ctrl, dra_dp and the top level.
package dra_pkg;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_MERGED   = 3'd1,
        ST_TOTAL    = 3'd2,
        ST_SOURCE   = 3'd3,
        ST_FULL     = 3'd4,
        ST_NO_ENTRY = 3'd5,
        ST_EMPTY    = 3'd6
    } status_code_t;

    localparam logic [1:0] CFG_LIMIT_TOTAL     = 2'd0;
    localparam logic [1:0] CFG_LIMIT_DISK_ONLY = 2'd1;
    localparam logic [1:0] CFG_LIMIT_GENERATE  = 2'd2;
    localparam logic [1:0] CFG_WORKER_COUNT    = 2'd3;

    localparam logic [15:0] RST_LIMIT_TOTAL     = 16'd128;
    localparam logic [15:0] RST_LIMIT_DISK_ONLY = 16'd100;
    localparam logic [15:0] RST_LIMIT_GENERATE  = 16'd32;
    localparam logic [2:0]  RST_WORKER_COUNT    = 3'd1;

    typedef struct packed {
        logic        valid;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [7:0]  peer;
        logic        no_peer;
        logic        gen;
        logic        force_flag;
    } entry_t;

    typedef struct packed {
        logic         clr_step;
        logic         accept;
        logic         mod_load_entry;
        logic         wscan_init;
        logic         wscan_step;
        logic         tscan_init;
        logic         tscan_step;
        logic         pop_take;
        logic         enq_merge;
        logic         enq_new;
        logic         enq_push;
        logic         pop_free;
        logic         src_dec;
        logic         out_load;
        status_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic wscan_done;
        logic tscan_done;
        logic total_hit;
        logic src_hit;
        logic fifo_full;
        logic match;
        logic free_found;
        logic pop_empty;
        logic out_free;
        logic is_pop;
        logic force_req;
        logic entry_no_peer;
    } dp_sts_t;

endpackage

@@ rtl/dedup_request_admission_dispatch.sv @@
`timescale 1ns / 1ps
// Deduplicating request admission and dispatch: top level with configuration
// registers. Depends on dra_pkg, dra_ctrl and dra_dp.
//
// Takes one request at a time on the slave stream. An enqueue (tuser=0) is
// checked against the total and per-requester limits unless forced, merged
// into a pending entry at the same position or given a fresh entry, and
// appended to the least-filled worker FIFO. A pop (tuser=1) takes the head of
// the selected FIFO, reports and frees its entry and returns the requester's
// count. After reset a clearing pass of max(TABLE_ENTRIES, SOURCES) steps,
// one a cycle, writes the table and counter entries; no request is taken
// until it ends, while configuration writes are taken at any time.
// The pending table sits in a memory with one read port, so every enqueue that
// passes the limit and FIFO checks and every pop that finds a FIFO item walks
// it once. The requester index is reduced modulo SOURCES by repeated
// subtraction before its counter is read. The result sits in an output
// register, so a new request is taken while a result waits for its transfer.
module dedup_request_admission_dispatch #(
    parameter int TABLE_ENTRIES = 64,
    parameter int SOURCES       = 256,
    parameter int WORKERS       = 4,
    parameter int QUEUE_DEPTH   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[15:0] pos_y[31:16] pos_z[47:32] peer_id[55:48] no_peer[56]
    // generate_ok[57] force_queue[58] worker_sel[60:59], zeros above
    input  logic [63:0] s_axis_tdata,
    // mode[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // worker_index[1:0] out_x[17:2] out_y[33:18] out_z[49:34]
    // out_generate_ok[50] out_force[51] out_peer[59:52] out_no_peer[60]
    output logic [63:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dra_pkg::*;

    localparam int WCW = $clog2(WORKERS + 1);

    logic [15:0]    limit_total_reg, limit_disk_only_reg, limit_generate_reg;
    logic [2:0]     worker_count_reg;
    logic [WCW-1:0] worker_n;
    dp_cmd_t        cmd;
    dp_sts_t        sts;

    // Configuration writes are always taken; the user writes only to an idle block.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_total_reg     <= RST_LIMIT_TOTAL;
            limit_disk_only_reg <= RST_LIMIT_DISK_ONLY;
            limit_generate_reg  <= RST_LIMIT_GENERATE;
            worker_count_reg    <= RST_WORKER_COUNT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LIMIT_TOTAL:     limit_total_reg     <= cfg_data;
                CFG_LIMIT_DISK_ONLY: limit_disk_only_reg <= cfg_data;
                CFG_LIMIT_GENERATE:  limit_generate_reg  <= cfg_data;
                CFG_WORKER_COUNT:    worker_count_reg    <= cfg_data[2:0];
                default:             limit_total_reg     <= limit_total_reg;
            endcase
        end
    end

    // Clamp the worker count: zero acts as one, anything above WORKERS as WORKERS.
    always_comb
    begin
        priority if (worker_count_reg == 3'd0)
            worker_n = WCW'(1);
        else if (32'(worker_count_reg) > WORKERS)
            worker_n = WCW'(WORKERS);
        else
            worker_n = WCW'(worker_count_reg);
    end

    dra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    dra_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SOURCES       (SOURCES),
        .WORKERS       (WORKERS),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_mode         (s_axis_tuser[0]),
        .in_data         (s_axis_tdata),
        .limit_total     (limit_total_reg),
        .limit_disk_only (limit_disk_only_reg),
        .limit_generate  (limit_generate_reg),
        .worker_n        (worker_n),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_data        (m_axis_tdata),
        .out_user        (m_axis_tuser)
    );

    // A new entry only goes into a free slot and never shadows a pending one.
    a_new_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_new |-> (sts.free_found && !sts.match))
        else $error("new entry without a free table slot");

    // Never push into a worker FIFO that is already full.
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq_push |-> !sts.fifo_full)
        else $error("push into full worker FIFO");

    // A pop only dequeues from a FIFO that holds an item.
    a_take_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_take |-> !sts.pop_empty)
        else $error("dequeue from empty worker FIFO");

    // A result is loaded only when the output register is free; it shows next cycle.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free ##1 m_axis_tvalid)
        else $error("result overwrote a pending transfer");

endmodule

@@ rtl/dra_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine for the admission and dispatch block.
// Depends on dra_pkg; drives dra_dp through dp_cmd_t / dp_sts_t.
module dra_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_mode,
    output logic             in_ready,
    output dra_pkg::dp_cmd_t cmd,
    input  dra_pkg::dp_sts_t sts
);
    import dra_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EMOD, S_ERD, S_ELIM, S_WSCAN, S_TSCAN, S_EDEC,
        S_PCHK, S_PGOT, S_PDEC, S_PMOD, S_PRD, S_PSUB, S_FIN
    } state_t;

    state_t       state_reg, state_next;
    status_code_t code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = !sts.clr_done;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = in_mode ? S_PCHK : S_EMOD;
                end
            end
            S_EMOD:
            begin
                if (sts.mod_done)
                    state_next = S_ERD;
            end
            S_ERD:
                state_next = S_ELIM;
            S_ELIM:
            begin
                priority if (!sts.force_req && sts.total_hit)
                begin
                    code_next  = ST_TOTAL;
                    state_next = S_FIN;
                end
                else if (!sts.force_req && sts.src_hit)
                begin
                    code_next  = ST_SOURCE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.wscan_init = 1'b1;
                    state_next     = S_WSCAN;
                end
            end
            S_WSCAN:
            begin
                cmd.wscan_step = 1'b1;
                if (sts.wscan_done)
                begin
                    if (sts.fifo_full)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.tscan_init = 1'b1;
                        state_next     = S_TSCAN;
                    end
                end
            end
            S_TSCAN:
            begin
                cmd.tscan_step = 1'b1;
                if (sts.tscan_done)
                    state_next = sts.is_pop ? S_PDEC : S_EDEC;
            end
            S_EDEC:
            begin
                state_next = S_FIN;
                priority if (sts.match)
                begin
                    cmd.enq_merge = 1'b1;
                    cmd.enq_push  = 1'b1;
                    code_next     = ST_MERGED;
                end
                else if (!sts.free_found)
                    code_next = ST_FULL;
                else
                begin
                    cmd.enq_new  = 1'b1;
                    cmd.enq_push = 1'b1;
                    code_next    = ST_NEW;
                end
            end
            S_PCHK:
            begin
                if (sts.pop_empty)
                begin
                    code_next  = ST_EMPTY;
                    state_next = S_FIN;
                end
                else
                    state_next = S_PGOT;
            end
            S_PGOT:
            begin
                cmd.pop_take   = 1'b1;
                cmd.tscan_init = 1'b1;
                state_next     = S_TSCAN;
            end
            S_PDEC:
            begin
                if (!sts.match)
                begin
                    code_next  = ST_NO_ENTRY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.pop_free       = 1'b1;
                    cmd.mod_load_entry = 1'b1;
                    code_next          = ST_NEW;
                    state_next         = sts.entry_no_peer ? S_FIN : S_PMOD;
                end
            end
            S_PMOD:
            begin
                if (sts.mod_done)
                    state_next = S_PRD;
            end
            S_PRD:
                state_next = S_PSUB;
            S_PSUB:
            begin
                cmd.src_dec = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_NEW;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

@@ rtl/dra_dp.sv @@
`timescale 1ns / 1ps
// Datapath: pending table, source counters, worker FIFOs, scans and result register.
// Depends on dra_pkg; commanded by dra_ctrl.
module dra_dp #(
    parameter int TABLE_ENTRIES = 64,
    parameter int SOURCES       = 256,
    parameter int WORKERS       = 4,
    parameter int QUEUE_DEPTH   = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dra_pkg::dp_cmd_t               cmd,
    output dra_pkg::dp_sts_t               sts,
    input  logic                           in_mode,
    input  logic [63:0]                    in_data,
    input  logic [15:0]                    limit_total,
    input  logic [15:0]                    limit_disk_only,
    input  logic [15:0]                    limit_generate,
    input  logic [$clog2(WORKERS+1)-1:0]   worker_n,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [63:0]                    out_data,
    output logic [2:0]                     out_user
);
    import dra_pkg::*;

    localparam int TW    = $clog2(TABLE_ENTRIES);
    localparam int TCW   = $clog2(TABLE_ENTRIES + 1);
    localparam int SW    = $clog2(SOURCES);
    localparam int WW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int WCW   = $clog2(WORKERS + 1);
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = WORKERS * QUEUE_DEPTH;
    localparam int SLW   = $clog2(SLOTS);
    localparam int CLR_N = (TABLE_ENTRIES > SOURCES) ? TABLE_ENTRIES : SOURCES;
    localparam int CLW   = $clog2(CLR_N + 1);

    // request registers
    logic        pop_reg, no_peer_reg, gen_reg, force_reg;
    logic [15:0] key_x_reg, key_y_reg, key_z_reg;
    logic [7:0]  peer_reg;
    logic [1:0]  sel_reg;

    // serial reduction of the requester index
    logic [7:0]    mod_reg;
    logic          mod_done;
    logic [SW-1:0] src;

    logic [CLW-1:0] clr_cnt_reg;
    logic           clr_done, clr_in_tbl, clr_in_src;

    entry_t         tbl_mem [TABLE_ENTRIES];
    entry_t         tbl_rdata_reg, tbl_wd;
    logic [TW-1:0]  tbl_ra, tbl_wa;
    logic           tbl_we;

    logic [15:0]    src_mem [SOURCES];
    logic [15:0]    src_cnt_reg, src_wd;
    logic [SW-1:0]  src_wa;
    logic           src_we;

    logic [TCW-1:0] ti_reg;
    logic           rd_valid_reg;
    logic [TW-1:0]  rd_idx_reg;
    logic           match_reg, free_reg, hit;
    logic [TW-1:0]  match_idx_reg, free_idx_reg;
    entry_t         match_ent_reg;

    logic [TCW-1:0] pending_count_reg;

    logic [QCW-1:0] fill_reg [WORKERS];
    logic [QW-1:0]  head_reg [WORKERS];
    logic [WCW-1:0] wi_reg;
    logic [WW-1:0]  best_reg, wi_idx, sel_idx;
    logic           wscan_done;
    logic [QW:0]    push_sum, pop_next;
    logic [QW-1:0]  push_off;

    logic [47:0]    slot_mem [SLOTS];
    logic [47:0]    slot_rdata_reg;
    logic [SLW-1:0] slot_wa, slot_ra;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic [15:0] lim;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pop_reg     <= in_mode;
            key_x_reg   <= in_data[15:0];
            key_y_reg   <= in_data[31:16];
            key_z_reg   <= in_data[47:32];
            peer_reg    <= in_data[55:48];
            no_peer_reg <= in_data[56];
            gen_reg     <= in_data[57];
            force_reg   <= in_data[58];
            sel_reg     <= in_data[60:59];
        end
        else if (cmd.pop_take)
        begin
            key_x_reg <= slot_rdata_reg[15:0];
            key_y_reg <= slot_rdata_reg[31:16];
            key_z_reg <= slot_rdata_reg[47:32];
        end
    end

    assign mod_done = 32'(mod_reg) < SOURCES;
    assign src      = SW'(mod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            mod_reg <= in_data[55:48];
        else if (cmd.mod_load_entry)
            mod_reg <= match_ent_reg.peer;
        else if (!mod_done)
            mod_reg <= mod_reg - 8'(SOURCES);
    end

    // clearing pass over both stores after reset
    assign clr_done   = clr_cnt_reg == CLW'(CLR_N);
    assign clr_in_tbl = clr_cnt_reg < CLW'(TABLE_ENTRIES);
    assign clr_in_src = clr_cnt_reg < CLW'(SOURCES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // pending table
    assign tbl_ra = (ti_reg < TCW'(TABLE_ENTRIES)) ? ti_reg[TW-1:0] : '0;

    always_comb
    begin
        tbl_we = 1'b0;
        tbl_wa = match_idx_reg;
        tbl_wd = match_ent_reg;
        priority if (cmd.clr_step && clr_in_tbl)
        begin
            tbl_we = 1'b1;
            tbl_wa = clr_cnt_reg[TW-1:0];
            tbl_wd = '0;
        end
        else if (cmd.enq_merge)
        begin
            tbl_we            = 1'b1;
            tbl_wd.gen        = match_ent_reg.gen | gen_reg;
            tbl_wd.force_flag = match_ent_reg.force_flag | force_reg;
        end
        else if (cmd.enq_new)
        begin
            tbl_we = 1'b1;
            tbl_wa = free_idx_reg;
            tbl_wd = '{valid: 1'b1, x: key_x_reg, y: key_y_reg, z: key_z_reg,
                       peer: peer_reg, no_peer: no_peer_reg, gen: gen_reg,
                       force_flag: force_reg};
        end
        else if (cmd.pop_free)
        begin
            tbl_we       = 1'b1;
            tbl_wd.valid = 1'b0;
        end
        else
            tbl_we = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_wa] <= tbl_wd;
        tbl_rdata_reg <= tbl_mem[tbl_ra];
    end

    // per-source counters
    always_comb
    begin
        src_we = 1'b0;
        src_wa = src;
        src_wd = src_cnt_reg;
        priority if (cmd.clr_step && clr_in_src)
        begin
            src_we = 1'b1;
            src_wa = clr_cnt_reg[SW-1:0];
            src_wd = '0;
        end
        else if (cmd.enq_new && !no_peer_reg)
        begin
            src_we = 1'b1;
            src_wd = (src_cnt_reg == 16'hFFFF) ? src_cnt_reg : src_cnt_reg + 16'd1;
        end
        else if (cmd.src_dec)
        begin
            src_we = 1'b1;
            src_wd = (src_cnt_reg == 16'd0) ? src_cnt_reg : src_cnt_reg - 16'd1;
        end
        else
            src_we = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[src_wa] <= src_wd;
        src_cnt_reg <= src_mem[src];
    end

    // table scan: the compare works on the registered read of the previous address
    assign hit = rd_valid_reg && tbl_rdata_reg.valid && tbl_rdata_reg.x == key_x_reg &&
                 tbl_rdata_reg.y == key_y_reg && tbl_rdata_reg.z == key_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ti_reg       <= '0;
            rd_valid_reg <= 1'b0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end
        else if (cmd.tscan_init)
        begin
            ti_reg       <= '0;
            rd_valid_reg <= 1'b0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
        end
        else if (cmd.tscan_step)
        begin
            if (ti_reg < TCW'(TABLE_ENTRIES))
            begin
                ti_reg       <= ti_reg + 1'b1;
                rd_valid_reg <= 1'b1;
            end
            else
                rd_valid_reg <= 1'b0;
            if (hit && !match_reg)
                match_reg <= 1'b1;
            if (rd_valid_reg && !tbl_rdata_reg.valid && !free_reg)
                free_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tscan_step)
        begin
            rd_idx_reg <= tbl_ra;
            if (hit && !match_reg)
            begin
                match_idx_reg <= rd_idx_reg;
                match_ent_reg <= tbl_rdata_reg;
            end
            if (rd_valid_reg && !tbl_rdata_reg.valid && !free_reg)
                free_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_count_reg <= '0;
        else if (cmd.enq_new)
            pending_count_reg <= pending_count_reg + 1'b1;
        else if (cmd.pop_free && pending_count_reg != '0)
            pending_count_reg <= pending_count_reg - 1'b1;
    end

    // worker FIFOs: least-filled search, lowest index on ties
    assign wi_idx     = wi_reg[WW-1:0];
    assign sel_idx    = WW'(sel_reg);
    assign wscan_done = wi_reg >= worker_n;
    assign push_sum   = (QW+1)'(head_reg[best_reg]) + (QW+1)'(fill_reg[best_reg]);
    assign push_off   = (push_sum >= (QW+1)'(QUEUE_DEPTH))
                        ? QW'(push_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(push_sum);
    assign pop_next   = (QW+1)'(head_reg[sel_idx]) + 1'b1;
    assign slot_wa    = SLW'(32'(best_reg) * QUEUE_DEPTH + 32'(push_off));
    assign slot_ra    = SLW'(32'(sel_idx) * QUEUE_DEPTH + 32'(head_reg[sel_idx]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            best_reg <= '0;
            for (int i = 0; i < WORKERS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.wscan_init)
            begin
                wi_reg   <= WCW'(1);
                best_reg <= '0;
            end
            else if (cmd.wscan_step && !wscan_done)
            begin
                if (fill_reg[wi_idx] < fill_reg[best_reg])
                    best_reg <= wi_idx;
                wi_reg <= wi_reg + 1'b1;
            end
            if (cmd.enq_push)
                fill_reg[best_reg] <= fill_reg[best_reg] + 1'b1;
            else if (cmd.pop_take)
            begin
                fill_reg[sel_idx] <= fill_reg[sel_idx] - 1'b1;
                head_reg[sel_idx] <= (pop_next == (QW+1)'(QUEUE_DEPTH)) ? '0 : QW'(pop_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq_push)
            slot_mem[slot_wa] <= {key_z_reg, key_y_reg, key_x_reg};
        slot_rdata_reg <= slot_mem[slot_ra];
    end

    // result register
    logic [1:0] o_widx;
    logic       show_pos, show_ent;

    always_comb
    begin
        show_pos = pop_reg && cmd.code != ST_EMPTY;
        show_ent = pop_reg && cmd.code == ST_NEW;
        if (pop_reg)
            o_widx = sel_reg;
        else if (cmd.code == ST_NEW || cmd.code == ST_MERGED)
            o_widx = 2'(best_reg);
        else
            o_widx = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_user_reg <= cmd.code;
            out_data_reg <= {3'b000,
                             show_ent & match_ent_reg.no_peer,
                             show_ent ? match_ent_reg.peer : 8'd0,
                             show_ent & match_ent_reg.force_flag,
                             show_ent & match_ent_reg.gen,
                             show_pos ? key_z_reg : 16'd0,
                             show_pos ? key_y_reg : 16'd0,
                             show_pos ? key_x_reg : 16'd0,
                             o_widx};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    assign lim = gen_reg ? limit_generate : limit_disk_only;

    always_comb
    begin
        sts               = '0;
        sts.clr_done      = clr_done;
        sts.mod_done      = mod_done;
        sts.wscan_done    = wscan_done;
        sts.tscan_done    = (ti_reg == TCW'(TABLE_ENTRIES)) && !rd_valid_reg;
        sts.total_hit     = 32'(pending_count_reg) >= 32'(limit_total);
        sts.src_hit       = !no_peer_reg && (src_cnt_reg >= lim);
        sts.fifo_full     = fill_reg[best_reg] >= QCW'(QUEUE_DEPTH);
        sts.match         = match_reg;
        sts.free_found    = free_reg;
        sts.pop_empty     = (32'(sel_reg) >= WORKERS) || (fill_reg[sel_idx] == '0);
        sts.out_free      = !out_valid_reg || out_ready;
        sts.is_pop        = pop_reg;
        sts.force_req     = force_reg;
        sts.entry_no_peer = match_ent_reg.no_peer;
    end

endmodule

@@ bench/dra_checker.sv @@
`timescale 1ns / 1ps
// Checker for the request admission and dispatch block: predicts each result
// from the accepted requests and compares it with the output stream.
// Depends on dra_pkg.
module dra_checker
    import dra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_results,
    output int          result_total,
    output int          pop_total
);

    localparam int TBL = 64;
    localparam int NWK = 4;
    localparam int QD  = 64;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] data;
    } outcome_t;

    outcome_t    expected_q[$];
    entry_t      table_m[TBL];
    int          table_used;
    logic [15:0] src_cnt[256];
    logic [47:0] fifo_m[NWK][QD];
    int          fill_m[NWK];
    int          head_m[NWK];
    logic [15:0] lim_total, lim_disk, lim_gen;
    logic [2:0]  wcount;

    assign pending_results = expected_q.size();

    function automatic int find_pos(logic [47:0] p);
        for (int i = 0; i < TBL; i++)
            if (table_m[i].valid && {table_m[i].z, table_m[i].y, table_m[i].x} == p)
                return i;
        return -1;
    endfunction

    function automatic outcome_t predict_request(logic mode, logic [63:0] d);
        outcome_t    r;
        logic [47:0] p;
        logic [7:0]  peer;
        logic        nop, gen, frc;
        int          sel, w, n, e, f;
        logic [15:0] lim;
        p = d[47:0];
        peer = d[55:48];
        nop = d[56];
        gen = d[57];
        frc = d[58];
        sel = int'(d[60:59]);
        r.status = ST_NEW;
        r.data = '0;
        if (mode)
        begin
            r.data[1:0] = 2'(sel);
            if (fill_m[sel] == 0)
            begin
                r.status = ST_EMPTY;
                return r;
            end
            p = fifo_m[sel][head_m[sel]];
            head_m[sel] = (head_m[sel] + 1) % QD;
            fill_m[sel]--;
            r.data[49:2] = p;
            e = find_pos(p);
            if (e < 0)
            begin
                r.status = ST_NO_ENTRY;
                return r;
            end
            r.data[50] = table_m[e].gen;
            r.data[51] = table_m[e].force_flag;
            r.data[59:52] = table_m[e].peer;
            r.data[60] = table_m[e].no_peer;
            if (!table_m[e].no_peer && src_cnt[table_m[e].peer] != 0)
                src_cnt[table_m[e].peer]--;
            table_m[e].valid = 1'b0;
            table_used--;
            return r;
        end
        if (!frc)
        begin
            if (table_used >= lim_total)
            begin
                r.status = ST_TOTAL;
                return r;
            end
            lim = gen ? lim_gen : lim_disk;
            if (!nop && src_cnt[peer] >= lim)
            begin
                r.status = ST_SOURCE;
                return r;
            end
        end
        // least-filled worker, lowest index on a tie
        n = (wcount == 0) ? 1 : (int'(wcount) > NWK ? NWK : int'(wcount));
        w = 0;
        for (int i = 1; i < n; i++)
            if (fill_m[i] < fill_m[w])
                w = i;
        e = find_pos(p);
        f = -1;
        if (fill_m[w] >= QD)
        begin
            r.status = ST_FULL;
            return r;
        end
        if (e < 0)
        begin
            for (int i = TBL - 1; i >= 0; i--)
                if (!table_m[i].valid)
                    f = i;
            if (f < 0)
            begin
                r.status = ST_FULL;
                return r;
            end
            table_m[f] = '{1'b1, p[15:0], p[31:16], p[47:32], peer, nop, gen, frc};
            table_used++;
            if (!nop && src_cnt[peer] != 16'hFFFF)
                src_cnt[peer]++;
        end
        else
        begin
            table_m[e].gen |= gen;
            table_m[e].force_flag |= frc;
            r.status = ST_MERGED;
        end
        fifo_m[w][(head_m[w] + fill_m[w]) % QD] = p;
        fill_m[w]++;
        r.data[1:0] = 2'(w);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            foreach (table_m[i]) table_m[i] = '0;
            foreach (src_cnt[i]) src_cnt[i] = '0;
            for (int i = 0; i < NWK; i++)
            begin
                fill_m[i] = 0;
                head_m[i] = 0;
            end
            table_used = 0;
            lim_total = RST_LIMIT_TOTAL;
            lim_disk = RST_LIMIT_DISK_ONLY;
            lim_gen = RST_LIMIT_GENERATE;
            wcount = RST_WORKER_COUNT;
            fail_count <= 0;
            result_total <= 0;
            pop_total <= 0;
        end
        else
        begin
            // compare the result first, the block cannot answer in the same cycle
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_total <= result_total + 1;
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result status=%0d data=%h",
                                 m_axis_tuser, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.status !== m_axis_tuser || want.data !== m_axis_tdata)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected status=%0d data=%h, got %0d %h",
                                     want.status, want.data, m_axis_tuser, m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                    else if (want.status == ST_NEW && m_axis_tdata[49:2] != 0)
                        pop_total <= pop_total + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.insert(expected_q.size(),
                                  predict_request(s_axis_tuser[0], s_axis_tdata));
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_LIMIT_TOTAL:     lim_total = cfg_data;
                    CFG_LIMIT_DISK_ONLY: lim_disk = cfg_data;
                    CFG_LIMIT_GENERATE:  lim_gen = cfg_data;
                    CFG_WORKER_COUNT:    wcount = cfg_data[2:0];
                    default: ;
                endcase
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the admission and dispatch bench: clock, reset, request stimulus,
// configuration phases and verdict. Depends on dra_pkg, dra_checker and the block.
module tb_top;
    import dra_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int fail_count, pending_results, result_total, pop_total;
    bit calm;            // no idling on either side while set
    bit hold_off;        // receiver stalls completely while set
    int req_count;

    // Small coordinate pool so merges, duplicate pops and limits happen often.
    logic [47:0] pos_pool[16];

    always #5 clk = ~clk;

    dedup_request_admission_dispatch dut (.*);

    dra_checker chk (.*);

    // Receiver: random stalls, with a long hold-off on request.
    always @(negedge clk)
        m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 7);

    // One write, with valid dropped again before the next can start.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one request and hold it until the transfer; valid stays up
    // afterwards, so a random idle gap or the drain drops it.
    task automatic send_request(input logic mode, input logic [63:0] d);
        if (!calm)
            while ($urandom_range(99) < 7)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_axis_tdata <= d;
        s_axis_tuser <= mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        req_count++;
    endtask

    function automatic logic [63:0] make_enq(logic [47:0] p, logic [7:0] peer,
                                             logic nop, logic gen, logic frc);
        return {3'b0, 2'b0, frc, gen, nop, peer, p};
    endfunction

    function automatic logic [63:0] make_pop(logic [1:0] sel);
        logic [63:0] d;
        d = {$urandom, $urandom};
        d[63:59] = {3'b0, sel};
        return d;
    endfunction

    function automatic logic [63:0] rand_enq();
        logic [47:0] p;
        p = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                     : pos_pool[$urandom_range(15)];
        return make_enq(p, 8'($urandom_range(1) ? $urandom_range(3) : $urandom),
                        $urandom_range(4) == 0, 1'($urandom_range(1)),
                        $urandom_range(9) == 0);
    endfunction

    // Drop the request, wait until every result is back, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic random_phase(input int count, input int pop_pct);
        for (int i = 0; i < count; i++)
            if ($urandom_range(99) < pop_pct)
                send_request(1'b1, make_pop(2'($urandom_range(3))));
            else
                send_request(1'b0, rand_enq());
    endtask

    initial
    begin
        foreach (pos_pool[i]) pos_pool[i] = 48'({$urandom, $urandom});
        pos_pool[0] = 48'h8000_8000_8000;
        pos_pool[1] = 48'h7FFF_7FFF_7FFF;
        req_count = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, merge, duplicate pop, empty pops and a pop of an unused worker.
        send_request(1'b1, make_pop(2'd0));
        send_request(1'b0, make_enq(pos_pool[0], 8'hFF, 1'b0, 1'b1, 1'b0));
        send_request(1'b0, make_enq(pos_pool[1], 8'h00, 1'b1, 1'b0, 1'b1));
        send_request(1'b0, make_enq(pos_pool[0], 8'h12, 1'b0, 1'b0, 1'b1));
        send_request(1'b0, make_enq(48'h0, 8'hAA, 1'b0, 1'b0, 1'b0));
        for (int i = 0; i < 5; i++)
            send_request(1'b1, make_pop(2'd0));
        send_request(1'b1, make_pop(2'd3));
        drain();

        // Tiny limits: total and source refusals, forced bypass.
        write_reg(CFG_LIMIT_TOTAL, 16'd2);
        write_reg(CFG_LIMIT_DISK_ONLY, 16'd1);
        write_reg(CFG_LIMIT_GENERATE, 16'd1);
        write_reg(CFG_WORKER_COUNT, 16'd4);
        send_request(1'b0, make_enq(pos_pool[2], 8'd5, 1'b0, 1'b0, 1'b0));
        send_request(1'b0, make_enq(pos_pool[3], 8'd5, 1'b0, 1'b1, 1'b0));
        send_request(1'b0, make_enq(pos_pool[3], 8'd6, 1'b0, 1'b1, 1'b0));
        send_request(1'b0, make_enq(pos_pool[4], 8'd7, 1'b1, 1'b0, 1'b0));
        send_request(1'b0, make_enq(pos_pool[4], 8'd5, 1'b0, 1'b1, 1'b1));
        for (int i = 0; i < 4; i++)
            send_request(1'b1, make_pop(i[1:0]));
        drain();

        // Zero limits and a worker count of zero.
        write_reg(CFG_LIMIT_TOTAL, 16'd0);
        write_reg(CFG_WORKER_COUNT, 16'd0);
        send_request(1'b0, rand_enq());
        drain();
        write_reg(CFG_LIMIT_TOTAL, 16'hFFFF);
        write_reg(CFG_LIMIT_DISK_ONLY, 16'd0);
        write_reg(CFG_LIMIT_GENERATE, 16'd0);
        send_request(1'b0, make_enq(pos_pool[5], 8'd9, 1'b0, 1'b1, 1'b0));
        send_request(1'b0, make_enq(pos_pool[5], 8'd9, 1'b0, 1'b0, 1'b0));
        drain();

        // Fill the table with forced enqueues of fresh positions, including a
        // long receiver hold-off so the block backs up its input.
        write_reg(CFG_LIMIT_DISK_ONLY, 16'hFFFF);
        write_reg(CFG_LIMIT_GENERATE, 16'hFFFF);
        write_reg(CFG_WORKER_COUNT, 16'd7);
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 70; i++)
                send_request(1'b0, make_enq(48'({$urandom, $urandom}), 8'($urandom),
                                            1'b0, 1'b1, 1'b1));
        join
        for (int i = 0; i < 70; i++)
            send_request(1'b1, make_pop(2'($urandom_range(3))));
        drain();

        // Random phases over several settings, one without idling.
        write_reg(CFG_LIMIT_TOTAL, 16'd20);
        write_reg(CFG_LIMIT_DISK_ONLY, 16'd3);
        write_reg(CFG_LIMIT_GENERATE, 16'd5);
        write_reg(CFG_WORKER_COUNT, 16'd2);
        random_phase(150, 40);
        drain();
        calm = 1'b1;
        write_reg(CFG_WORKER_COUNT, 16'd3);
        random_phase(150, 45);
        drain();
        calm = 1'b0;
        write_reg(CFG_LIMIT_TOTAL, RST_LIMIT_TOTAL);
        write_reg(CFG_LIMIT_DISK_ONLY, RST_LIMIT_DISK_ONLY);
        write_reg(CFG_LIMIT_GENERATE, RST_LIMIT_GENERATE);
        write_reg(CFG_WORKER_COUNT, 16'd4);
        random_phase(150, 45);
        for (int i = 0; i < 80; i++)
            send_request(1'b1, make_pop(2'($urandom_range(3))));
        drain();

        $display("ran %0d requests, %0d results checked, %0d entries popped",
                 req_count, result_total, pop_total);
        $display("limits at zero, small and full scale; 0 to 7 workers; table full");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Roughly 700 requests plus stalls and hold-off.
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
